/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/salru_pkg.sv */
// Types and constants of the set-associative LRU cache model.
package salru_pkg;
	localparam int SETS_DEF       = 64;
	localparam int WAYS_DEF       = 8;
	localparam int ADDR_WIDTH_DEF = 64;
	localparam int AGE_WIDTH_DEF  = 32;
	localparam int CNT_W          = 32;
	localparam int RF_DEPTH       = 2;

	typedef enum logic [1:0] {
		CMD_IFETCH,
		CMD_LOAD,
		CMD_STORE,
		CMD_MODIFY
	} cmd_t;

	localparam logic [1:0] OUTC_HIT   = 2'd0;
	localparam logic [1:0] OUTC_FILL  = 2'd1;
	localparam logic [1:0] OUTC_EVICT = 2'd2;

	localparam logic [1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [1:0] CFG_WAYS       = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

	localparam logic [2:0] SET_BITS_RST   = 3'd0;
	localparam logic [3:0] WAYS_RST       = 4'd1;
	localparam logic [5:0] BLOCK_BITS_RST = 6'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] address;
	} request_t;

	typedef struct packed {
		logic [1:0]       outcome;
		logic [CNT_W-1:0] hits_total;
		logic [CNT_W-1:0] misses_total;
		logic [CNT_W-1:0] evictions_total;
		logic             last_of_item;
	} result_t;

	// head of the access queue between front and back
	typedef struct packed {
		logic valid;
		logic dual;
	} op_ctl_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} back_state_t;
endpackage

/* sv/salru_front.sv */
// Front end: accepts requests, splits the address, queues accesses for the back end.
module salru_front #(
	parameter int SETS       = salru_pkg::SETS_DEF,
	parameter int ADDR_WIDTH = salru_pkg::ADDR_WIDTH_DEF,
	localparam int SW        = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  salru_pkg::request_t   request,
	input  logic [2:0]            set_bits,
	input  logic [5:0]            block_bits,
	output salru_pkg::op_ctl_t    op_ctl,
	output logic [SW-1:0]         op_set,
	output logic [ADDR_WIDTH-1:0] op_tag,
	input  logic                  op_pop
);
	import salru_pkg::*;

	localparam int SB_MAX = $clog2(SETS + 1) - 1;
	localparam logic [3:0] SB_MAX4 = 4'(SB_MAX);

	logic [SW-1:0]         set_q [2];
	logic [ADDR_WIDTH-1:0] tag_q [2];
	logic [1:0]            dual_q;
	logic                  wr_q, rd_q;
	logic [1:0]            cnt_q;

	logic [ADDR_WIDTH-1:0] addr, shifted, set_mask, set_full, tag;
	logic [3:0]            sb;
	logic                  push_op;

	always_comb begin
		addr     = request.address[ADDR_WIDTH-1:0];
		sb       = ({1'b0, set_bits} > SB_MAX4) ? SB_MAX4 : {1'b0, set_bits};
		shifted  = addr >> block_bits;
		set_mask = (ADDR_WIDTH'(1) << sb) - ADDR_WIDTH'(1);
		set_full = shifted & set_mask;
		tag      = addr >> (7'(block_bits) + 7'(sb));
	end

	assign full    = (cnt_q == 2'd2);
	// fetches are taken and dropped here
	assign push_op = push && !full && (request.command != CMD_IFETCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			cnt_q  <= 2'd0;
			dual_q <= 2'b00;
		end else begin
			if (push_op) begin
				wr_q         <= !wr_q;
				dual_q[wr_q] <= (request.command == CMD_MODIFY);
			end
			if (op_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push_op) - 2'(op_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_op) begin
			set_q[wr_q] <= set_full[SW-1:0];
			tag_q[wr_q] <= tag;
		end
	end

	assign op_ctl.valid = (cnt_q != 2'd0);
	assign op_ctl.dual  = dual_q[rd_q];
	assign op_set       = set_q[rd_q];
	assign op_tag       = tag_q[rd_q];
endmodule

/* sv/salru_back.sv */
// Back end: tag store read-modify-write, LRU choice and running counters.
module salru_back #(
	parameter int SETS       = salru_pkg::SETS_DEF,
	parameter int WAYS       = salru_pkg::WAYS_DEF,
	parameter int ADDR_WIDTH = salru_pkg::ADDR_WIDTH_DEF,
	parameter int AGE_WIDTH  = salru_pkg::AGE_WIDTH_DEF,
	localparam int SW        = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [3:0]            ways_in_use,
	input  salru_pkg::op_ctl_t    op_ctl,
	input  logic [SW-1:0]         op_set,
	input  logic [ADDR_WIDTH-1:0] op_tag,
	output logic                  op_pop,
	input  logic                  rf_room,
	output logic                  rf_push,
	output salru_pkg::result_t    rf_data
);
	import salru_pkg::*;

	localparam logic [4:0] WAYS5 = 5'(WAYS);

	logic [WAYS-1:0]            v_mem [SETS];
	logic [WAYS*ADDR_WIDTH-1:0] t_mem [SETS];
	logic [WAYS*AGE_WIDTH-1:0]  a_mem [SETS];

	logic [WAYS-1:0]            v_rd_q;
	logic [WAYS*ADDR_WIDTH-1:0] t_rd_q;
	logic [WAYS*AGE_WIDTH-1:0]  a_rd_q;

	back_state_t       state_q, state_d;
	logic [SW-1:0]     clr_q;
	logic              second_q;
	logic [CNT_W-1:0]  hits_q, misses_q, evicts_q;

	logic              rd_en, wr_en, clr_done;
	logic [4:0]        ew;
	logic              hit, inv_found;
	logic [3:0]        pick_hit, pick_inv, pick_old, pick;
	logic [AGE_WIDTH-1:0] best;
	logic [1:0]        outcome;
	logic [WAYS-1:0]            v_new;
	logic [WAYS*ADDR_WIDTH-1:0] t_new;
	logic [WAYS*AGE_WIDTH-1:0]  a_new;
	logic [AGE_WIDTH-1:0]       age_w;

	assign ew = (ways_in_use == 4'd0) ? 5'd1 :
		({1'b0, ways_in_use} > WAYS5) ? WAYS5 : {1'b0, ways_in_use};
	assign clr_done = (clr_q == SW'(SETS - 1));

	always_comb begin
		hit       = 1'b0;
		inv_found = 1'b0;
		pick_hit  = 4'd0;
		pick_inv  = 4'd0;
		pick_old  = 4'd0;
		best      = a_rd_q[AGE_WIDTH-1:0];
		for (int w = 0; w < WAYS; w++) begin
			if (5'(w) < ew) begin
				if (!hit && v_rd_q[w] && t_rd_q[w*ADDR_WIDTH +: ADDR_WIDTH] == op_tag) begin
					hit      = 1'b1;
					pick_hit = 4'(w);
				end
				if (!inv_found && !v_rd_q[w]) begin
					inv_found = 1'b1;
					pick_inv  = 4'(w);
				end
				if (w > 0 && a_rd_q[w*AGE_WIDTH +: AGE_WIDTH] > best) begin
					best     = a_rd_q[w*AGE_WIDTH +: AGE_WIDTH];
					pick_old = 4'(w);
				end
			end
		end
		if (hit) begin
			pick    = pick_hit;
			outcome = OUTC_HIT;
		end else if (inv_found) begin
			pick    = pick_inv;
			outcome = OUTC_FILL;
		end else begin
			pick    = pick_old;
			outcome = OUTC_EVICT;
		end
		v_new = v_rd_q;
		t_new = t_rd_q;
		a_new = a_rd_q;
		for (int w = 0; w < WAYS; w++) begin
			age_w = a_rd_q[w*AGE_WIDTH +: AGE_WIDTH];
			if (5'(w) < ew) begin
				if (4'(w) == pick) begin
					a_new[w*AGE_WIDTH +: AGE_WIDTH] = '0;
					if (!hit) begin
						v_new[w] = 1'b1;
						t_new[w*ADDR_WIDTH +: ADDR_WIDTH] = op_tag;
					end
				end else if (age_w != {AGE_WIDTH{1'b1}}) begin
					a_new[w*AGE_WIDTH +: AGE_WIDTH] = age_w + AGE_WIDTH'(1);
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		op_pop  = 1'b0;
		rf_push = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (op_ctl.valid && rf_room) begin
					rd_en   = 1'b1;
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				wr_en   = 1'b1;
				rf_push = 1'b1;
				op_pop  = !op_ctl.dual || second_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			second_q <= 1'b0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + SW'(1);
			if (rf_push) begin
				second_q <= op_ctl.dual && !second_q;
				hits_q   <= hits_q + CNT_W'(outcome == OUTC_HIT);
				misses_q <= misses_q + CNT_W'(outcome != OUTC_HIT);
				evicts_q <= evicts_q + CNT_W'(outcome == OUTC_EVICT);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			v_mem[clr_q] <= '0;
			a_mem[clr_q] <= '0;
		end else if (wr_en) begin
			v_mem[op_set] <= v_new;
			t_mem[op_set] <= t_new;
			a_mem[op_set] <= a_new;
		end
		if (rd_en) begin
			v_rd_q <= v_mem[op_set];
			t_rd_q <= t_mem[op_set];
			a_rd_q <= a_mem[op_set];
		end
	end

	assign rf_data.outcome         = outcome;
	assign rf_data.hits_total      = hits_q + CNT_W'(outcome == OUTC_HIT);
	assign rf_data.misses_total    = misses_q + CNT_W'(outcome != OUTC_HIT);
	assign rf_data.evictions_total = evicts_q + CNT_W'(outcome == OUTC_EVICT);
	assign rf_data.last_of_item    = !op_ctl.dual || second_q;
endmodule

/* sv/salru_rfifo.sv */
// Result queue in front of the output port.
module salru_rfifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_en,
	input  salru_pkg::result_t din,
	output logic               room,
	output logic               empty,
	input  logic               pop,
	output salru_pkg::result_t dout
);
	import salru_pkg::*;

	localparam int PW = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
	localparam int CW = $clog2(RF_DEPTH + 1);

	result_t       data_q [RF_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign empty  = (cnt_q == '0);
	assign room   = (cnt_q != CW'(RF_DEPTH));
	assign do_pop = pop && !empty;
	assign dout   = data_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_en)
				wr_q <= (wr_q == PW'(RF_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(RF_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push_en) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_en)
			data_q[wr_q] <= din;
	end
endmodule

/* sv/set_assoc_cache_lru_model_unit.sv */
// Set-associative LRU cache model: top level.
// Requests enter through push/full: one command and a byte address per transaction.
// Results leave through empty/pop: outcome, running hit/miss/eviction counts and
// last_of_item. A load or store gives one result, a modify two, a fetch none.
// Config writes (cfg_valid/cfg_ready, always ready) pick set bits, ways in use
// and block bits; write them only while no access is in flight.
// In the back end each access first reads the set's row from the
// tag/valid/age memories, then chooses a way and writes the row back. A modify
// thus runs as two accesses; a fetch is dropped by the front end as it is accepted.
// With empty queues a result passes the access queue, the row read and the
// lookup before it shows on the output.
// After reset the back end clears the valid and age memories set by set;
// requests queue up meanwhile (up to two) and then wait.
// When the receiver does not pop, the two-entry result queue fills, the back end
// holds, the two-entry access queue fills and full rises.
`include "assert_macros.svh"
module set_assoc_cache_lru_model_unit #(
	parameter int SETS       = salru_pkg::SETS_DEF,
	parameter int WAYS       = salru_pkg::WAYS_DEF,
	parameter int ADDR_WIDTH = salru_pkg::ADDR_WIDTH_DEF,
	parameter int AGE_WIDTH  = salru_pkg::AGE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  salru_pkg::request_t request,
	output logic                empty,
	input  logic                pop,
	output salru_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [5:0]          cfg_data
);
	import salru_pkg::*;

	localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;

	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] block_bits_q;

	op_ctl_t               op_ctl;
	logic [SW-1:0]         op_set;
	logic [ADDR_WIDTH-1:0] op_tag;
	logic                  op_pop, rf_room, rf_push;
	result_t               rf_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			ways_q       <= WAYS_RST;
			block_bits_q <= BLOCK_BITS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				CFG_WAYS:       ways_q       <= cfg_data[3:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	salru_front #(.SETS(SETS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.set_bits(set_bits_q), .block_bits(block_bits_q),
		.op_ctl(op_ctl), .op_set(op_set), .op_tag(op_tag), .op_pop(op_pop)
	);

	salru_back #(
		.SETS(SETS), .WAYS(WAYS), .ADDR_WIDTH(ADDR_WIDTH), .AGE_WIDTH(AGE_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .ways_in_use(ways_q),
		.op_ctl(op_ctl), .op_set(op_set), .op_tag(op_tag), .op_pop(op_pop),
		.rf_room(rf_room), .rf_push(rf_push), .rf_data(rf_data)
	);

	salru_rfifo u_rfifo (
		.clk(clk), .arst_n(arst_n), .push_en(rf_push), .din(rf_data),
		.room(rf_room), .empty(empty), .pop(pop), .dout(result)
	);

	`ASSERT_ALWAYS(a_rf_no_overflow, clk, arst_n, !(rf_push && !rf_room), "result queue overflow")
	`ASSERT_ALWAYS(a_pop_has_op, clk, arst_n, !(op_pop && !op_ctl.valid), "pop of empty access queue")
	`ASSERT_NEXT(a_push_spaced, clk, arst_n, rf_push, !rf_push, "back-to-back result pushes")
endmodule
